// ===== hdl/msp_pkg.sv =====
// Shared types and constants for the mixed-radix sum parser.
// Used by every module of the block but msp_fifo; depends on nothing else.
package msp_pkg;

  localparam int TOTAL_W = 64;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR   = 2'd1;
  localparam logic [1:0] ST_END_IN_NUM = 2'd2;
  localparam logic [1:0] ST_EXTRA      = 2'd3;

  // Byte classes produced by the front end
  localparam logic [3:0] CLS_DIGIT  = 4'd0;
  localparam logic [3:0] CLS_HEXLET = 4'd1;
  localparam logic [3:0] CLS_X      = 4'd2;
  localparam logic [3:0] CLS_PLUS   = 4'd3;
  localparam logic [3:0] CLS_MINUS  = 4'd4;
  localparam logic [3:0] CLS_SPACE  = 4'd5;
  localparam logic [3:0] CLS_NL     = 4'd6;
  localparam logic [3:0] CLS_OTHER  = 4'd7;
  localparam logic [3:0] CLS_END    = 4'd8;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [TOTAL_W-1:0] total;
    logic [7:0]                bad_char;
  } out_item_t;

  typedef struct packed {
    logic [3:0] cls;
    logic [3:0] digit;
    logic [7:0] ch;
  } cls_item_t;

endpackage

// ===== hdl/mixed_radix_sum_parser.sv =====
// Top level of the mixed-radix sum parser: front end, evaluator and result queue.
// Depends on msp_pkg, msp_front and msp_back.
//
// The parser takes one ASCII byte per transfer (or an end marker) and evaluates a line of
// sums such as "12 + 0x1F - 7", with decimal and 0x-prefixed hex numbers, wrapping at
// SUM_BITS bits. It accepts one item every cycle while full is low: the front end classifies
// each byte into a two-entry queue, and the evaluator consumes one queued byte per cycle,
// while the result queue has room, with a single shift-add and one sum update, which sets
// the rate. Each byte is registered in the front queue and each result in the result queue;
// either side may stall on its own: full rises only once both queues have backed up.
module mixed_radix_sum_parser #(
  parameter int SUM_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  msp_pkg::in_item_t  item,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output msp_pkg::out_item_t result
);

  msp_pkg::cls_item_t q_item;
  logic               q_empty;
  logic               q_pop;

  msp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .q_empty (q_empty)
  );

  msp_back #(
    .SUM_BITS(SUM_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

// ===== hdl/msp_fifo.sv =====
// Two-entry register queue used for the parser's classified-byte and result queues.
// Generic over its data width; depends on no package.
module msp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/msp_front.sv =====
// Front end: accepts input bytes, classifies each one and queues it.
// Depends on msp_pkg and msp_fifo.
module msp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  msp_pkg::in_item_t  item,
  output logic               full,
  input  logic               q_pop,
  output msp_pkg::cls_item_t q_item,
  output logic               q_empty
);

  msp_pkg::cls_item_t cls_item;
  logic [7:0]         c;

  assign c = item.char_in;

  always_comb begin
    cls_item.ch    = c;
    cls_item.digit = 4'd0;
    if (item.end_marker) begin
      cls_item.cls = msp_pkg::CLS_END;
    end else if (c inside {["0":"9"]}) begin
      cls_item.cls   = msp_pkg::CLS_DIGIT;
      cls_item.digit = 4'(c - 8'h30);
    end else if (c inside {["a":"f"]}) begin
      cls_item.cls   = msp_pkg::CLS_HEXLET;
      cls_item.digit = 4'(c - 8'h57);
    end else if (c inside {["A":"F"]}) begin
      cls_item.cls   = msp_pkg::CLS_HEXLET;
      cls_item.digit = 4'(c - 8'h37);
    end else if (c == "x" || c == "X") begin
      cls_item.cls = msp_pkg::CLS_X;
    end else if (c == "+") begin
      cls_item.cls = msp_pkg::CLS_PLUS;
    end else if (c == "-") begin
      cls_item.cls = msp_pkg::CLS_MINUS;
    end else if (c == 8'h0A) begin
      cls_item.cls = msp_pkg::CLS_NL;
    end else if (c == " " || c == 8'h09 || c == 8'h0D) begin
      cls_item.cls = msp_pkg::CLS_SPACE;
    end else begin
      cls_item.cls = msp_pkg::CLS_OTHER;
    end
  end

  msp_fifo #(
    .WIDTH($bits(msp_pkg::cls_item_t))
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls_item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

endmodule

// ===== hdl/msp_back.sv =====
// Back end: evaluates classified bytes, keeps the running sum and queues results.
// Depends on msp_pkg and msp_fifo.
module msp_back #(
  parameter int SUM_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  msp_pkg::cls_item_t q_item,
  input  logic               q_empty,
  output logic               q_pop,
  output msp_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);

  localparam logic [1:0] PH_BETWEEN = 2'd0;
  localparam logic [1:0] PH_ZERO    = 2'd1;
  localparam logic [1:0] PH_DEC     = 2'd2;
  localparam logic [1:0] PH_HEX     = 2'd3;

  logic [SUM_BITS-1:0] running_sum, running_sum_next;
  logic [SUM_BITS-1:0] number_value, number_value_next;
  logic [1:0]          phase, phase_next;
  logic                subtract_mode, subtract_mode_next;
  logic                line_ended, line_ended_next;

  logic                out_full;
  logic                step;
  logic                emit;
  msp_pkg::out_item_t  emit_item;
  logic [SUM_BITS-1:0] digit_ext;
  logic [SUM_BITS-1:0] accum;
  logic [SUM_BITS-1:0] committed;
  logic                in_num;
  logic                is_digit;
  logic                is_term;

  assign step  = !q_empty && !out_full;
  assign q_pop = step;

  assign digit_ext = SUM_BITS'(q_item.digit);
  assign in_num    = (phase != PH_BETWEEN);
  assign is_digit  = (q_item.cls == msp_pkg::CLS_DIGIT) ||
                     (phase == PH_HEX && q_item.cls == msp_pkg::CLS_HEXLET);
  assign is_term   = (q_item.cls == msp_pkg::CLS_SPACE) || (q_item.cls == msp_pkg::CLS_NL) ||
                     (q_item.cls == msp_pkg::CLS_PLUS) || (q_item.cls == msp_pkg::CLS_MINUS);

  // Shift-add by the radix; hex digits slot into the low nibble.
  always_comb begin
    if (phase == PH_HEX) begin
      accum = (number_value << 4) | digit_ext;
    end else begin
      accum = (number_value << 3) + (number_value << 1) + digit_ext;
    end
  end

  assign committed = subtract_mode ? (running_sum - number_value)
                                   : (running_sum + number_value);

  always_comb begin
    running_sum_next   = running_sum;
    number_value_next  = number_value;
    phase_next         = phase;
    subtract_mode_next = subtract_mode;
    line_ended_next    = line_ended;
    emit               = 1'b0;
    emit_item.status   = msp_pkg::ST_OK;
    emit_item.total    = '0;
    emit_item.bad_char = 8'd0;

    if (q_item.cls == msp_pkg::CLS_END) begin
      emit = 1'b1;
      if (!in_num) begin
        emit_item.total = msp_pkg::TOTAL_W'($signed(running_sum));
      end else begin
        emit_item.status = msp_pkg::ST_END_IN_NUM;
      end
    end else if (line_ended && q_item.cls != msp_pkg::CLS_NL) begin
      emit             = 1'b1;
      emit_item.status = msp_pkg::ST_EXTRA;
    end else if (phase == PH_ZERO && q_item.cls == msp_pkg::CLS_X) begin
      phase_next = PH_HEX;
    end else if (in_num && is_digit) begin
      number_value_next = accum;
      phase_next        = (phase == PH_ZERO) ? PH_DEC : phase;
    end else if (in_num && !is_term) begin
      emit               = 1'b1;
      emit_item.status   = msp_pkg::ST_BAD_CHAR;
      emit_item.bad_char = q_item.ch;
    end else begin
      // A terminator closes any open number before it takes effect itself.
      if (in_num) begin
        running_sum_next  = committed;
        number_value_next = '0;
        phase_next        = PH_BETWEEN;
      end
      case (q_item.cls)
        msp_pkg::CLS_NL:    line_ended_next = 1'b1;
        msp_pkg::CLS_SPACE: ;
        msp_pkg::CLS_PLUS:  subtract_mode_next = 1'b0;
        msp_pkg::CLS_MINUS: subtract_mode_next = 1'b1;
        msp_pkg::CLS_DIGIT: begin
          number_value_next = digit_ext;
          phase_next        = (q_item.digit == 4'd0) ? PH_ZERO : PH_DEC;
        end
        default: begin
          emit               = 1'b1;
          emit_item.status   = msp_pkg::ST_BAD_CHAR;
          emit_item.bad_char = q_item.ch;
        end
      endcase
    end

    // Every result leaves the parser ready for a fresh line.
    if (emit) begin
      running_sum_next   = '0;
      number_value_next  = '0;
      phase_next         = PH_BETWEEN;
      subtract_mode_next = 1'b0;
      line_ended_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      number_value  <= '0;
      phase         <= PH_BETWEEN;
      subtract_mode <= 1'b0;
      line_ended    <= 1'b0;
    end else if (step) begin
      running_sum   <= running_sum_next;
      number_value  <= number_value_next;
      phase         <= phase_next;
      subtract_mode <= subtract_mode_next;
      line_ended    <= line_ended_next;
    end
  end

  msp_fifo #(
    .WIDTH($bits(msp_pkg::out_item_t))
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (step && emit),
    .wdata (emit_item),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ===== hdl/msp_checker.sv =====
// Port-level checks for the mixed-radix sum parser, bound to the top level.
// Depends on msp_pkg and mixed_radix_sum_parser.
module msp_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input msp_pkg::out_item_t result
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_fault_no_total: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != msp_pkg::ST_OK) |-> result.total == '0)
    else $error("non-zero total carried with a fault status");

  a_bad_char_only: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != msp_pkg::ST_BAD_CHAR) |-> result.bad_char == 8'd0)
    else $error("offending byte reported without an unexpected character");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(result))
    else $error("waiting result changed before its transfer");

endmodule

bind mixed_radix_sum_parser msp_checker u_msp_checker (.*);
